[hw/rtl/lzd_pkg.sv]
// lzd_pkg: shared types for the lz77 token decoder
// byte type and the control structs passed between the copy sequencer and the byte stage
// depends on nothing
`timescale 1ns / 1ps

package lzd_pkg;

    localparam int BYTE_W = 8;

    typedef logic [BYTE_W-1:0] byte_t;

    // one issued byte, sequencer to byte stage
    typedef struct packed {
        logic valid;   // a byte is issued this cycle
        logic lit;     // byte is the token literal, no history read
        logic last;    // final byte of the token
        logic fwd;     // source is the entry being written this cycle
        logic filled;  // source entry has been written since reset
    } lzd_issue_t;

    // history write-back, byte stage to sequencer and memory
    typedef struct packed {
        logic  en;
        byte_t data;
    } lzd_wb_t;

endpackage

[hw/rtl/lzd_history_ram.sv]
// lzd_history_ram: sliding-window history, one write port and one registered read port
// depends on lzd_pkg
`timescale 1ns / 1ps

module lzd_history_ram #(
    parameter int DIST_BITS = 12
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [DIST_BITS-1:0] wr_addr,
    input  lzd_pkg::byte_t       wr_data,
    input  logic                 rd_en,
    input  logic [DIST_BITS-1:0] rd_addr,
    output lzd_pkg::byte_t       rd_data
);
    import lzd_pkg::*;

    localparam int DEPTH = 1 << DIST_BITS;

    byte_t mem [DEPTH];
    byte_t rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data held between reads
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/lzd_copy_seq.sv]
// lzd_copy_seq: token register, byte counter and history read addressing
// tracks the fill of the history since reset and flags read-during-write forwarding
// depends on lzd_pkg
`timescale 1ns / 1ps

module lzd_copy_seq #(
    parameter int LEN_BITS  = 4,
    parameter int DIST_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // token transaction
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [LEN_BITS-1:0]  match_length,
    input  logic [DIST_BITS-1:0] match_distance,
    input  lzd_pkg::byte_t       literal_byte,
    // byte stage
    input  logic                 stage_free,
    output lzd_pkg::lzd_issue_t  issue,
    output lzd_pkg::byte_t       issue_lit_byte,
    output logic [DIST_BITS-1:0] issue_pos,
    input  lzd_pkg::lzd_wb_t     wb,
    input  logic [DIST_BITS-1:0] wb_addr,
    // history read
    output logic                 rd_en,
    output logic [DIST_BITS-1:0] rd_addr
);
    import lzd_pkg::*;

    logic [LEN_BITS-1:0]  rem_reg, rem_next;
    logic [DIST_BITS-1:0] dist_reg, dist_next;
    logic                 lit_reg, lit_next;
    byte_t                lit_byte_reg, lit_byte_next;
    logic [DIST_BITS-1:0] pos_reg, pos_next;
    logic                 wrapped_reg, wrapped_next;

    logic                 issue_fire;
    logic                 load;
    logic [DIST_BITS-1:0] src;

    // issue one byte whenever the byte stage can take it
    assign issue_fire = (rem_reg != '0) && stage_free;
    assign in_stall   = !((rem_reg == '0) ||
                          ((rem_reg == LEN_BITS'(1)) && issue_fire));
    assign load       = in_valid && !in_stall;

    // source entry sits distance+1 behind the next write position
    assign src = pos_reg - dist_reg - DIST_BITS'(1);

    assign rd_en   = issue_fire && !lit_reg;
    assign rd_addr = src;

    // issued byte description
    always_comb
    begin
        issue.valid    = issue_fire;
        issue.lit      = lit_reg;
        issue.last     = (rem_reg == LEN_BITS'(1));
        issue.fwd      = wb.en && (wb_addr == src);
        issue.filled   = wrapped_reg || (src < pos_reg);
        issue_lit_byte = lit_byte_reg;
        issue_pos      = pos_reg;
    end

    // token and position next state
    always_comb
    begin
        rem_next      = rem_reg;
        dist_next     = dist_reg;
        lit_next      = lit_reg;
        lit_byte_next = lit_byte_reg;
        pos_next      = pos_reg;
        wrapped_next  = wrapped_reg;
        if (issue_fire)
        begin
            rem_next = rem_reg - LEN_BITS'(1);
            pos_next = pos_reg + DIST_BITS'(1);
            if (&pos_reg)
            begin
                wrapped_next = 1'b1;
            end
        end
        if (load)
        begin
            lit_next      = (match_length == '0);
            rem_next      = (match_length == '0) ? LEN_BITS'(1) : match_length;
            dist_next     = match_distance;
            lit_byte_next = literal_byte;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            pos_reg     <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            rem_reg     <= rem_next;
            pos_reg     <= pos_next;
            wrapped_reg <= wrapped_next;
        end
    end

    // token payload registers
    always_ff @(posedge clk)
    begin
        dist_reg     <= dist_next;
        lit_reg      <= lit_next;
        lit_byte_reg <= lit_byte_next;
    end

`ifndef SYNTH
    // each issued byte advances the write position by one
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        issue_fire |=> (pos_reg == $past(pos_reg) + DIST_BITS'(1)))
        else $error("write position did not advance on issue");

    // a new token only loads once the current one is on its last byte
    a_load_gap: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> ((rem_reg == '0) || (rem_reg == LEN_BITS'(1))))
        else $error("token loaded over unfinished copy");

    // the token channel is open whenever no copy is running
    a_idle_open: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg == '0) |-> !in_stall)
        else $error("token channel stalled while idle");
`endif

endmodule

[hw/rtl/lzd_byte_stage.sv]
// lzd_byte_stage: resolves each byte from memory, forward path or literal,
// writes it back to the history and holds it in the output register
// depends on lzd_pkg
`timescale 1ns / 1ps

module lzd_byte_stage #(
    parameter int DIST_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // from sequencer
    input  lzd_pkg::lzd_issue_t  issue,
    input  lzd_pkg::byte_t       issue_lit_byte,
    input  logic [DIST_BITS-1:0] issue_pos,
    output logic                 stage_free,
    // history
    input  lzd_pkg::byte_t       rd_data,
    output lzd_pkg::lzd_wb_t     wb,
    output logic [DIST_BITS-1:0] wb_addr,
    // byte transaction
    output logic                 out_valid,
    input  logic                 out_stall,
    output lzd_pkg::byte_t       out_byte,
    output logic                 last_of_run
);
    import lzd_pkg::*;

    logic                 p_valid_reg, p_valid_next;
    logic                 p_lit_reg;
    logic                 p_last_reg;
    logic                 p_fwd_reg;
    logic                 p_filled_reg;
    byte_t                p_lit_byte_reg;
    byte_t                p_fwd_byte_reg;
    logic [DIST_BITS-1:0] p_pos_reg;

    logic                 out_valid_reg, out_valid_next;
    byte_t                out_byte_reg;
    logic                 last_reg;

    logic                 out_free;
    logic                 p_adv;
    byte_t                cur_byte;

    assign out_free   = !out_valid_reg || !out_stall;
    assign p_adv      = p_valid_reg && out_free;
    assign stage_free = !p_valid_reg || p_adv;

    // byte select: literal, forwarded write, stored entry or unwritten zero
    always_comb
    begin
        if (p_lit_reg)
        begin
            cur_byte = p_lit_byte_reg;
        end
        else if (p_fwd_reg)
        begin
            cur_byte = p_fwd_byte_reg;
        end
        else if (p_filled_reg)
        begin
            cur_byte = rd_data;
        end
        else
        begin
            cur_byte = '0;
        end
    end

    // write-back as the byte moves to the output register
    assign wb.en   = p_adv;
    assign wb.data = cur_byte;
    assign wb_addr = p_pos_reg;

    // valid flags next state
    always_comb
    begin
        p_valid_next = p_valid_reg;
        if (p_adv)
        begin
            p_valid_next = 1'b0;
        end
        if (issue.valid)
        begin
            p_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (p_adv)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // pending byte payload
    always_ff @(posedge clk)
    begin
        if (issue.valid)
        begin
            p_lit_reg      <= issue.lit;
            p_last_reg     <= issue.last;
            p_fwd_reg      <= issue.fwd;
            p_filled_reg   <= issue.filled;
            p_lit_byte_reg <= issue_lit_byte;
            p_fwd_byte_reg <= cur_byte;
            p_pos_reg      <= issue_pos;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (p_adv)
        begin
            out_byte_reg <= cur_byte;
            last_reg     <= p_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign last_of_run = last_reg;

`ifndef SYNTH
    // a new byte is never issued over a pending one that cannot move
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        issue.valid |-> (!p_valid_reg || out_free))
        else $error("issued byte overwrote pending byte");

    // a blocked pending byte keeps its history position
    a_pending_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (p_valid_reg && !out_free) |=> (p_valid_reg && $stable(p_pos_reg)))
        else $error("blocked pending byte changed");

    // forwarding is only flagged against a write that really happens
    a_fwd_needs_write: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.fwd) |-> wb.en)
        else $error("forward flagged without write-back");
`endif

endmodule

[hw/rtl/lz77_token_decoder.sv]
// lz77_token_decoder: top level of the lz77 token decoder
// instantiates lzd_copy_seq, lzd_history_ram and lzd_byte_stage; depends on lzd_pkg
//
//   channel  handshake            payload
//   -------  -------------------  ---------------------------------------------
//   token    in_valid / in_stall  match_length, match_distance, literal_byte
//   byte     out_valid/out_stall  out_byte, last_of_run
//
// A literal token issues one byte; a match token issues match_length bytes, one
// history read per cycle while the byte stage is free, through the single read port
// of the history ram. Issued bytes pass the pending and then the output register.
// Reset clears control state only; unwritten history entries read as zero by a fill
// mark on the write position, so there is no clearing pass after reset.
// out_stall holds the output register, then the pending byte and the sequencer.
`timescale 1ns / 1ps

module lz77_token_decoder #(
    parameter int LEN_BITS  = 4,
    parameter int DIST_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [LEN_BITS-1:0]  match_length,
    input  logic [DIST_BITS-1:0] match_distance,
    input  lzd_pkg::byte_t       literal_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output lzd_pkg::byte_t       out_byte,
    output logic                 last_of_run
);
    import lzd_pkg::*;

    lzd_issue_t           issue;
    byte_t                issue_lit_byte;
    logic [DIST_BITS-1:0] issue_pos;
    logic                 stage_free;
    lzd_wb_t              wb;
    logic [DIST_BITS-1:0] wb_addr;
    logic                 rd_en;
    logic [DIST_BITS-1:0] rd_addr;
    byte_t                rd_data;

    // token register and read addressing
    lzd_copy_seq #(
        .LEN_BITS  (LEN_BITS),
        .DIST_BITS (DIST_BITS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .match_length   (match_length),
        .match_distance (match_distance),
        .literal_byte   (literal_byte),
        .stage_free     (stage_free),
        .issue          (issue),
        .issue_lit_byte (issue_lit_byte),
        .issue_pos      (issue_pos),
        .wb             (wb),
        .wb_addr        (wb_addr),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr)
    );

    // history window
    lzd_history_ram #(
        .DIST_BITS (DIST_BITS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wb.en),
        .wr_addr (wb_addr),
        .wr_data (wb.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // byte resolve, write-back and output register
    lzd_byte_stage #(
        .DIST_BITS (DIST_BITS)
    ) u_stage (
        .clk            (clk),
        .rst_n          (rst_n),
        .issue          (issue),
        .issue_lit_byte (issue_lit_byte),
        .issue_pos      (issue_pos),
        .stage_free     (stage_free),
        .rd_data        (rd_data),
        .wb             (wb),
        .wb_addr        (wb_addr),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_byte       (out_byte),
        .last_of_run    (last_of_run)
    );

endmodule
